>>> rtl/bdla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdla_pkg
// Shared widths, limits, register indexes and types of the bob deinterlacer.
// ----------------------------------------------------------------------------
package bdla_pkg;

  localparam int MAX_LINE_BYTES = 4096;
  localparam int MAX_ROWS       = 2048;

  localparam int BYTE_W = 8;
  localparam int ROW_W  = 11;
  localparam int COL_W  = 12;
  localparam int LB_W   = 13;   // line_bytes register
  localparam int FR_W   = 12;   // frame_rows register
  localparam int CFG_W  = 13;   // widest register
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] CFG_LINE_BYTES   = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_ROWS   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BOTTOM_FIELD = 2'd2;

  localparam logic [LB_W-1:0] LINE_BYTES_RST = 13'd800;
  localparam logic [FR_W-1:0] FRAME_ROWS_RST = 12'd150;
  localparam logic [LB_W-1:0] LINE_BYTES_MAX = LB_W'(MAX_LINE_BYTES);
  localparam logic [FR_W-1:0] FRAME_ROWS_MAX = FR_W'(MAX_ROWS);

  // which result of a job goes out next
  typedef enum logic [1:0] {
    PH_PRE,   // copy to row 0 or average to the row above
    PH_MAIN,  // the byte itself
    PH_POST   // copy to the last row
  } phase_t;

  // accepted byte, waiting for the registered line store read
  typedef struct packed {
    logic              keep;
    logic [BYTE_W-1:0] pix;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              has_pre;
    logic              pre_avg;
    logic [ROW_W-1:0]  pre_row;
    logic              has_post;
    logic [ROW_W-1:0]  post_row;
    logic              fdone;
  } stage_t;

  // kept byte with all its results resolved
  typedef struct packed {
    logic [BYTE_W-1:0] pix;
    logic [BYTE_W-1:0] pre_pix;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              has_pre;
    logic [ROW_W-1:0]  pre_row;
    logic              has_post;
    logic [ROW_W-1:0]  post_row;
    logic              fdone;
  } job_t;

endpackage
`default_nettype wire

>>> rtl/bdla_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdla stream interfaces
// Valid/ready channels for frame bytes in and placed result bytes out.
// ----------------------------------------------------------------------------
interface bdla_in_if import bdla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] pixel_byte;

  modport source (output valid, output pixel_byte, input ready);
  modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface bdla_out_if import bdla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;
  logic              last_of_run;
  logic              frame_done;

  modport source (output valid, output out_byte, output out_row, output out_col,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input out_byte, input out_row, input out_col,
                  input last_of_run, input frame_done, output ready);
endinterface
`default_nettype wire

>>> rtl/bdla_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdla_ram
// Generic simple dual-port RAM, registered read, read-before-write.
// ----------------------------------------------------------------------------
module bdla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/bob_deinterlace_line_average.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bob_deinterlace_line_average
// Bob deinterlacer: keeps one field of a raster byte stream, rebuilds the
// missing rows by averaging the kept rows around them.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------------
//  in_chan | in  | valid/ready   | pixel_byte[7:0]
//  out_chan| out | valid/ready   | out_byte[7:0] out_row[10:0] out_col[11:0]
//          |     |               | last_of_run frame_done
//  cfg     | in  | cfg_we only   | cfg_idx[1:0] cfg_data[12:0]
//
//  A request is taken every cycle while the pipe moves; a dropped-field byte
//  takes no job slot. A kept byte issues 1 to 3 results, one per cycle while
//  out_chan does not stall; on the top field the first row gives a single
//  result and the last kept row three. The next byte waits in the read stage.
//  rst_n clears control and registers; line store columns are written first.
//  A stall on out_chan backs up through the job and read stages to in_chan.
//
module bob_deinterlace_line_average
  import bdla_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  bdla_in_if.sink                in_chan,
  bdla_out_if.source             out_chan,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  // ---------------- configuration registers
  logic [LB_W-1:0] line_bytes_r;
  logic [FR_W-1:0] frame_rows_r;
  logic            bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= LINE_BYTES_RST;
      frame_rows_r <= FRAME_ROWS_RST;
      bottom_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LINE_BYTES:   line_bytes_r <= cfg_data[LB_W-1:0];
        CFG_FRAME_ROWS:   frame_rows_r <= cfg_data[FR_W-1:0];
        CFG_BOTTOM_FIELD: bottom_r     <= cfg_data[0];
        default: ;  // index past the list: ignored
      endcase
    end
  end

  // effective frame size: row count made even, both clamped to the legal range
  logic [LB_W-1:0] w_eff;
  logic [FR_W-1:0] h_eff;
  logic [FR_W-1:0] h_even;

  always_comb begin
    if (line_bytes_r == '0) begin
      w_eff = LB_W'(1);
    end else if (line_bytes_r > LINE_BYTES_MAX) begin
      w_eff = LINE_BYTES_MAX;
    end else begin
      w_eff = line_bytes_r;
    end
    h_even = {frame_rows_r[FR_W-1:1], 1'b0};
    if (h_even == '0) begin
      h_eff = FR_W'(2);
    end else if (h_even > FRAME_ROWS_MAX) begin
      h_eff = FRAME_ROWS_MAX;
    end else begin
      h_eff = h_even;
    end
  end

  // ---------------- pipeline control
  logic   s1_v_r, job_v_r, out_v_r;
  logic   s1_v_nxt, job_v_nxt, out_v_nxt;
  stage_t s1_r, s1_nxt;
  job_t   job_r, job_nxt;
  phase_t phase_r, phase_nxt;

  logic in_acc, s1_adv, job_load, out_load, is_final, job_done;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_load = job_v_r && (!out_v_r || out_chan.ready);
  assign is_final = (phase_r == PH_POST) || (phase_r == PH_MAIN && !job_r.has_post);
  assign job_done = out_load && is_final;
  // dropped bytes leave the read stage without taking a job slot
  assign s1_adv   = s1_v_r && (!s1_r.keep || !job_v_r || job_done);
  assign job_load = s1_adv && s1_r.keep;
  assign in_chan.ready = !s1_v_r || s1_adv;

  // ---------------- raster position
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [LB_W-1:0]  col_inc;
  logic [FR_W-1:0]  row_inc;

  always_comb begin
    col_inc = LB_W'(col_r) + LB_W'(1);
    row_inc = FR_W'(row_r) + FR_W'(1);
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  // ---------------- classify the byte at accept
  logic [FR_W-1:0] h_m1, h_m2;

  always_comb begin
    h_m1 = h_eff - FR_W'(1);
    h_m2 = h_eff - FR_W'(2);
    s1_nxt      = s1_r;
    s1_nxt.pix  = in_chan.pixel_byte;
    s1_nxt.row  = row_r;
    s1_nxt.col  = col_r;
    s1_nxt.keep = (FR_W'(row_r) < h_eff) && (LB_W'(col_r) < w_eff)
                  && (row_r[0] == bottom_r);
    if (row_r <= ROW_W'(1)) begin
      // first kept row: the bottom field copies it up to row 0
      s1_nxt.has_pre = bottom_r;
      s1_nxt.pre_avg = 1'b0;
      s1_nxt.pre_row = '0;
    end else begin
      s1_nxt.has_pre = 1'b1;
      s1_nxt.pre_avg = 1'b1;
      s1_nxt.pre_row = row_r - ROW_W'(1);
    end
    // top field: last kept row is also copied to the last frame row
    s1_nxt.has_post = !bottom_r && (FR_W'(row_r) == h_m2);
    s1_nxt.post_row = h_m1[ROW_W-1:0];
    s1_nxt.fdone    = (LB_W'(col_r) == w_eff - LB_W'(1))
                      && (s1_nxt.has_post || FR_W'(row_r) == h_m1);
  end

  // ---------------- line store: previous kept row
  logic [BYTE_W-1:0] store_rd;

  bdla_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (in_acc && s1_nxt.keep),
    .waddr (col_r),
    .wdata (in_chan.pixel_byte),
    .re    (in_acc),
    .raddr (col_r),
    .rdata (store_rd)
  );

  // ---------------- resolve job: average with the stored byte
  logic [BYTE_W:0] sum;

  always_comb begin
    sum = {1'b0, store_rd} + {1'b0, s1_r.pix};
    job_nxt.pix      = s1_r.pix;
    job_nxt.pre_pix  = s1_r.pre_avg ? sum[BYTE_W:1] : s1_r.pix;
    job_nxt.row      = s1_r.row;
    job_nxt.col      = s1_r.col;
    job_nxt.has_pre  = s1_r.has_pre;
    job_nxt.pre_row  = s1_r.pre_row;
    job_nxt.has_post = s1_r.has_post;
    job_nxt.post_row = s1_r.post_row;
    job_nxt.fdone    = s1_r.fdone;
  end

  // ---------------- valid bits and result sequencing
  always_comb begin
    s1_v_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    job_v_nxt = job_load ? 1'b1 : (job_done ? 1'b0 : job_v_r);
    out_v_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_v_r);
    phase_nxt = phase_r;
    if (job_load) begin
      phase_nxt = s1_r.has_pre ? PH_PRE : PH_MAIN;
    end else if (out_load) begin
      unique case (phase_r)
        PH_PRE:  phase_nxt = PH_MAIN;
        PH_MAIN: phase_nxt = PH_POST;
        PH_POST: phase_nxt = PH_POST;
        default: phase_nxt = PH_MAIN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      job_v_r <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= PH_MAIN;
      row_r   <= '0;
      col_r   <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      job_v_r <= job_v_nxt;
      out_v_r <= out_v_nxt;
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
    if (job_load) begin
      job_r <= job_nxt;
    end
  end

  // ---------------- result register
  logic [BYTE_W-1:0] res_byte_r, res_byte_nxt;
  logic [ROW_W-1:0]  res_row_r, res_row_nxt;
  logic [COL_W-1:0]  res_col_r;
  logic              res_last_r, res_fd_r;

  always_comb begin
    unique case (phase_r)
      PH_PRE: begin
        res_byte_nxt = job_r.pre_pix;
        res_row_nxt  = job_r.pre_row;
      end
      PH_POST: begin
        res_byte_nxt = job_r.pix;
        res_row_nxt  = job_r.post_row;
      end
      default: begin
        res_byte_nxt = job_r.pix;
        res_row_nxt  = job_r.row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_byte_r <= res_byte_nxt;
      res_row_r  <= res_row_nxt;
      res_col_r  <= job_r.col;
      res_last_r <= is_final;
      res_fd_r   <= is_final && job_r.fdone;
    end
  end

  assign out_chan.valid       = out_v_r;
  assign out_chan.out_byte    = res_byte_r;
  assign out_chan.out_row     = res_row_r;
  assign out_chan.out_col     = res_col_r;
  assign out_chan.last_of_run = res_last_r;
  assign out_chan.frame_done  = res_fd_r;

endmodule
`default_nettype wire

>>> rtl/bdla_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bdla_checker
// Port-level checks of the deinterlacer, bound to the top level.
// ----------------------------------------------------------------------------
module bdla_checker
  import bdla_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BYTE_W-1:0] out_byte,
  input wire logic [ROW_W-1:0]  out_row,
  input wire logic [COL_W-1:0]  out_col,
  input wire logic              out_last,
  input wire logic              out_fdone
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_row)
      && $stable(out_col) && $stable(out_last) && $stable(out_fdone))
    else $error("result changed while stalled");

  // end of frame closes a run
  a_fd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fdone |-> out_last)
    else $error("frame_done without last_of_run");

  // a run continues without a gap
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a run of results");

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bob_deinterlace_line_average bdla_checker u_bdla_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .out_row   (out_chan.out_row),
  .out_col   (out_chan.out_col),
  .out_last  (out_chan.last_of_run),
  .out_fdone (out_chan.frame_done)
);
`default_nettype wire

>>> tb/sv/tb_bob_deinterlace_line_average.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bob_deinterlace_line_average
// Streams frames through the bob deinterlacer and predicts every placed byte
// (kept rows, averaged rows, edge copies) with row, column and end flags.
// Both stream sides idle and stall at random. A result queue is checked in
// order, field by field.
// ----------------------------------------------------------------------------
module tb_bob_deinterlace_line_average;
  import bdla_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 8;     // drains the read, job and result stages
  localparam int unsigned HOLD_CYCLES    = 80;    // long output hold-off
  localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles with no request moving
  localparam int unsigned RANDOM_ITEMS   = 130;

  // one expected result: a byte placed at its output row and column
  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              run_end;
    logic              frame_end;
  } placed_byte_t;

  logic clk = 1'b0;
  logic rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]  cfg_data;

  bdla_in_if  in_bus ();
  bdla_out_if out_bus ();

  bob_deinterlace_line_average u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Deinterlacer mirror: registers as last written, raster position of the
  // next input byte, and the previous kept row.
  // --------------------------------------------------------------------------
  logic [LB_W-1:0]   line_bytes_q  = LINE_BYTES_RST;
  logic [FR_W-1:0]   frame_rows_q  = FRAME_ROWS_RST;
  logic              bottom_q      = 1'b0;
  int unsigned       row_pos       = 0;
  int unsigned       col_pos       = 0;
  logic [BYTE_W-1:0] prev_kept_row [MAX_LINE_BYTES] = '{default: '0};

  placed_byte_t placed_bytes_due[$];

  // stimulus controls, shared with the output side
  bit          src_gaps_on    = 1'b1;
  bit          sink_stalls_on = 1'b1;
  bit          hold_req       = 1'b0;
  int unsigned bytes_sent     = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;

  task automatic flag_error(input string msg);
    $display("%0t ns: ERROR %s", $time, msg);
    error_count++;
  endtask

  // row length in use: 0 acts as 1, clamped to the store size
  function automatic int unsigned eff_width();
    int unsigned w;
    w = line_bytes_q;
    if (w == 0) w = 1;
    if (w > MAX_LINE_BYTES) w = MAX_LINE_BYTES;
    return w;
  endfunction

  // row count in use: low bit dropped, at least 2, clamped to MAX_ROWS
  function automatic int unsigned eff_height();
    int unsigned h;
    h = {frame_rows_q[FR_W-1:1], 1'b0};
    if (h == 0) h = 2;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  function automatic placed_byte_t place(input int unsigned v, r, c);
    placed_byte_t p;
    p.value     = BYTE_W'(v);
    p.row       = ROW_W'(r);
    p.col       = COL_W'(c);
    p.run_end   = 1'b0;
    p.frame_end = 1'b0;
    return p;
  endfunction

  // Queues the results of one accepted byte and advances the raster position.
  task automatic deinterlace_byte(input logic [BYTE_W-1:0] b);
    int unsigned w, h, r, c, last_row, first;
    w = eff_width();
    h = eff_height();
    r = row_pos;
    c = col_pos;
    first = placed_bytes_due.size();
    // rows of the other field and positions left outside by a register
    // change produce nothing
    if (r < h && c < w && (r & 1) == bottom_q) begin
      if (r <= 1) begin
        // first kept row: the bottom field also fills row 0
        if (bottom_q) placed_bytes_due.push_back(place(b, 0, c));
      end else begin
        // missing row above: truncated mean of the two kept rows
        placed_bytes_due.push_back(
          place((int'(prev_kept_row[c]) + int'(b)) >> 1, r - 1, c));
      end
      placed_bytes_due.push_back(place(b, r, c));
      last_row = r;
      // top field: last kept row is repeated into the final row
      if (!bottom_q && r == h - 2) begin
        placed_bytes_due.push_back(place(b, h - 1, c));
        last_row = h - 1;
      end
      prev_kept_row[c] = b;
      placed_bytes_due[placed_bytes_due.size() - 1].run_end = 1'b1;
      if (c == w - 1 && last_row == h - 1)
        placed_bytes_due[placed_bytes_due.size() - 1].frame_end = 1'b1;
      if (placed_bytes_due.size() < first) flag_error("result queue shrank");
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Shared stimulus helpers
  // --------------------------------------------------------------------------

  // mostly short pauses, now and then a long one
  function automatic int unsigned pause_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one byte and returns at the edge where the request is taken.
  // valid stays high into the next call unless that call starts with a gap.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = 0;
    if (src_gaps_on && $urandom_range(0, 2) == 0) gap = pause_len();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.pixel_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    deinterlace_byte(b);
    bytes_sent++;
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_byte(BYTE_W'($urandom));
  endtask

  // Whole frames from the current position. Stripes alternate 0xFF / 0x00
  // every two rows, so each averaged byte has an odd sum.
  task automatic send_frames(input int unsigned n, input bit stripes);
    int unsigned total;
    total = n * eff_width() * eff_height();
    repeat (total) begin
      if (stripes) send_byte((row_pos & 2) != 0 ? 8'h00 : 8'hFF);
      else send_byte(BYTE_W'($urandom));
    end
  endtask

  // random bytes up to the next frame start
  task automatic finish_frame();
    while (row_pos != 0 || col_pos != 0) send_byte(BYTE_W'($urandom));
  endtask

  // Drops valid, waits for every queued result, then lets bytes that
  // produce nothing drain out of the pipe.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (placed_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all three registers, one per cycle, once the block is idle.
  task automatic program_regs(input int unsigned lb, fr, input bit bot);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_LINE_BYTES;
    cfg_data <= CFG_W'(lb);
    @(posedge clk);
    cfg_idx  <= CFG_FRAME_ROWS;
    cfg_data <= CFG_W'(fr);
    @(posedge clk);
    cfg_idx  <= CFG_BOTTOM_FIELD;
    cfg_data <= CFG_W'(bot);
    @(posedge clk);
    cfg_we <= 1'b0;
    line_bytes_q = LB_W'(lb);
    frame_rows_q = FR_W'(fr);
    bottom_q     = bot;
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready pattern, checks and watchdog
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input logic [COL_W-1:0] got, want,
                             input placed_byte_t exp);
    if (got !== want)
      flag_error($sformatf("row %0d col %0d %s: got %0h expected %0h",
                           exp.row, exp.col, field, got, want));
  endtask

  task automatic check_result();
    placed_byte_t exp;
    if (placed_bytes_due.size() == 0) begin
      flag_error($sformatf("result at row %0d col %0d with nothing pending",
                           out_bus.out_row, out_bus.out_col));
      return;
    end
    exp = placed_bytes_due.pop_front();
    check_field("out_byte",    COL_W'(out_bus.out_byte),    COL_W'(exp.value),     exp);
    check_field("out_row",     COL_W'(out_bus.out_row),     COL_W'(exp.row),       exp);
    check_field("out_col",     out_bus.out_col,             exp.col,               exp);
    check_field("last_of_run", COL_W'(out_bus.last_of_run), COL_W'(exp.run_end),   exp);
    check_field("frame_done",  COL_W'(out_bus.frame_done),  COL_W'(exp.frame_end), exp);
  endtask

  // Drives out ready once per loop pass; a hold request keeps it low for a
  // long counted stretch so the pipe fills and in ready drops.
  initial begin : result_sink
    int unsigned n;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_bus.ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        n = pause_len();
        repeat (n - 1) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Samples at the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles = 0;
    end else begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (out_bus.valid && out_bus.ready) check_result();
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset registers (800 x 150, top field): start of row 0, byte extremes.
  task automatic test_reset_values();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    send_byte(8'h01);
    send_byte(8'h80);
  endtask

  // Register changes that leave the position outside the frame.
  task automatic test_outside_frame();
    // column 6 is past a 2-byte row: no result, moves on to row 1
    program_regs(2, 8, 0);
    send_random(1);
    finish_frame();
    // stop at row 5, then shrink to 4 rows: row 5 yields nothing and wraps
    send_random(10);
    program_regs(2, 4, 0);
    send_random(2);
    finish_frame();
  endtask

  // Both fields, edge rows, odd and too small sizes.
  task automatic test_field_edges();
    program_regs(3, 6, 0);
    send_frames(1, 1'b1);
    program_regs(3, 6, 1);
    send_frames(1, 1'b1);
    program_regs(2, 7, 1);      // odd row count acts as 6
    send_frames(1, 1'b0);
    program_regs(0, 0, 0);      // 1 byte by 2 rows
    send_frames(2, 1'b0);
    program_regs(0, 1, 1);      // same size, bottom field
    send_frames(2, 1'b0);
  endtask

  // Widest row and tallest frame, plus the clamps above them. The start of
  // the widest row also fills every column the random frames use.
  task automatic test_largest_sizes();
    program_regs(LINE_BYTES_MAX, 2, 0);
    send_random(16);
    program_regs(8191, 2, 0);   // clamped to the widest row, same position
    send_random(4);
    program_regs(1, 2, 0);      // column 20 now past the row end
    finish_frame();
    program_regs(0, 4095, 1);   // 1 byte wide, clamped to MAX_ROWS rows
    send_random(12);
    program_regs(1, 2, 0);      // row 12 now past the frame end
    finish_frame();
  endtask

  // Output held off while input is offered back to back.
  task automatic test_output_stall();
    program_regs(4, 4, 0);
    src_gaps_on = 1'b0;
    hold_req    = 1'b1;
    send_frames(3, 1'b0);
    src_gaps_on = 1'b1;
  endtask

  // Random settings; mostly whole frames, some cut short by a change.
  task automatic test_random_frames();
    int unsigned start, lb, pick;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      src_gaps_on    = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) lb = 0;
      else if (pick == 1) lb = $urandom_range(7, 12);
      else lb = $urandom_range(1, 6);
      program_regs(lb, $urandom_range(0, 9), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0) begin
        send_random($urandom_range(1, 2 * eff_width() * eff_height()));
      end else begin
        finish_frame();
        send_frames($urandom_range(1, 2), 1'b0);
      end
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    in_bus.valid      <= 1'b0;
    in_bus.pixel_byte <= '0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CFG_LINE_BYTES;
    cfg_data          <= '0;
    rst_n             <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_outside_frame();
    test_field_edges();
    test_largest_sizes();
    test_output_stall();
    test_random_frames();

    wait_idle();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
